// File: rtl/tbbmc_pkg.sv
// shared types and constants for the two-button blink mode controller
// event and mode codes, register reset values, button status struct
`timescale 1ns / 1ps
`default_nettype none

package tbbmc_pkg;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_B1_CLICK = 3'd1,
    EV_B2_CLICK = 3'd2,
    EV_B1_HOLD  = 3'd3,
    EV_B2_HOLD  = 3'd4,
    EV_BOTH     = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    MODE_OFF        = 3'd0,
    MODE_FAST_SYNC  = 3'd1,
    MODE_SLOW_SYNC  = 3'd2,
    MODE_SLOW_ALT   = 3'd3,
    MODE_FAST_ALT   = 3'd4
  } mode_t;

  localparam int unsigned REG_W = 16;

  typedef enum logic [1:0] {
    REG_HOLD_TIME   = 2'd0,
    REG_MIN_CLICK   = 2'd1,
    REG_SLOW_PERIOD = 2'd2,
    REG_FAST_PERIOD = 2'd3
  } reg_index_t;

  localparam logic [REG_W-1:0] HOLD_TIME_RST   = 16'd1000;
  localparam logic [REG_W-1:0] MIN_CLICK_RST   = 16'd50;
  localparam logic [REG_W-1:0] SLOW_PERIOD_RST = 16'd1000;
  localparam logic [REG_W-1:0] FAST_PERIOD_RST = 16'd200;

  typedef struct packed {
    logic last;
    logic hold;
    logic click;
  } btn_status_t;

endpackage

`default_nettype wire

// File: rtl/two_button_blink_mode_controller.sv
// two-button blink mode controller top level: config registers, event select,
// output register; depends on tbbmc_pkg, tbbmc_button, tbbmc_blink
// the result word is registered in the cycle after its input word is accepted
// throughput: one word per cycle unless m_tready stalls; the output register frees as it is taken
// reset: synchronous rst clears button, blink and mode state and the output
// valid, and loads the register defaults (1000, 50, 1000, 200)
`timescale 1ns / 1ps
`default_nettype none

module two_button_blink_mode_controller #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [1:0]                    cfg_index,
  input  wire [tbbmc_pkg::REG_W-1:0]   cfg_data,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire [7:0]                    s_tdata,  // btn1_pressed, btn2_pressed, zero pad
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [7:0]                   m_tdata   // button_event, blink_mode, red_led, blue_led
);

  logic [tbbmc_pkg::REG_W-1:0] hold_time;
  logic [tbbmc_pkg::REG_W-1:0] min_click;
  logic [tbbmc_pkg::REG_W-1:0] slow_period;
  logic [tbbmc_pkg::REG_W-1:0] fast_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time   <= tbbmc_pkg::HOLD_TIME_RST;
      min_click   <= tbbmc_pkg::MIN_CLICK_RST;
      slow_period <= tbbmc_pkg::SLOW_PERIOD_RST;
      fast_period <= tbbmc_pkg::FAST_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (tbbmc_pkg::reg_index_t'(cfg_index))
        tbbmc_pkg::REG_HOLD_TIME:   hold_time   <= cfg_data;
        tbbmc_pkg::REG_MIN_CLICK:   min_click   <= cfg_data;
        tbbmc_pkg::REG_SLOW_PERIOD: slow_period <= cfg_data;
        tbbmc_pkg::REG_FAST_PERIOD: fast_period <= cfg_data;
        default: ;
      endcase
    end
  end

  logic step;
  logic b1;
  logic b2;
  logic combo;

  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;
  assign b1       = s_tdata[0];
  assign b2       = s_tdata[1];
  assign combo    = b1 && b2;

  tbbmc_pkg::btn_status_t st1;
  tbbmc_pkg::btn_status_t st2;

  tbbmc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn1 (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pressed   (b1),
    .combo     (combo),
    .hold_time (hold_time),
    .min_click (min_click),
    .status    (st1)
  );

  tbbmc_button #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn2 (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pressed   (b2),
    .combo     (combo),
    .hold_time (hold_time),
    .min_click (min_click),
    .status    (st2)
  );

  tbbmc_pkg::event_t ev;

  always_comb begin
    priority if (combo) begin
      ev = (st1.last && st2.last) ? tbbmc_pkg::EV_NONE : tbbmc_pkg::EV_BOTH;
    end else if (st2.hold) begin
      ev = tbbmc_pkg::EV_B2_HOLD;
    end else if (st2.click) begin
      ev = tbbmc_pkg::EV_B2_CLICK;
    end else if (st1.hold) begin
      ev = tbbmc_pkg::EV_B1_HOLD;
    end else if (st1.click) begin
      ev = tbbmc_pkg::EV_B1_CLICK;
    end else begin
      ev = tbbmc_pkg::EV_NONE;
    end
  end

  tbbmc_pkg::mode_t mode_next;
  logic             red;
  logic             blue;

  tbbmc_blink #(.COUNT_WIDTH(COUNT_WIDTH)) u_blink (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .ev          (ev),
    .slow_period (slow_period),
    .fast_period (fast_period),
    .mode_next   (mode_next),
    .red         (red),
    .blue        (blue)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {blue, red, mode_next, ev};
    end
  end

  a_combo_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == tbbmc_pkg::EV_BOTH) |-> (m_tdata[5:3] == tbbmc_pkg::MODE_OFF))
    else $error("combo event without off mode");

  a_off_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5:3] == tbbmc_pkg::MODE_OFF) |-> (m_tdata[7:6] == 2'b00))
    else $error("leds lit in off mode");

  a_sync_leds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tdata[5:3] == tbbmc_pkg::MODE_FAST_SYNC) ||
                 (m_tdata[5:3] == tbbmc_pkg::MODE_SLOW_SYNC)) |-> (m_tdata[6] == m_tdata[7]))
    else $error("sync mode leds differ");

  a_alt_leds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tdata[5:3] == tbbmc_pkg::MODE_FAST_ALT) ||
                 (m_tdata[5:3] == tbbmc_pkg::MODE_SLOW_ALT)) |-> (m_tdata[6] != m_tdata[7]))
    else $error("alternate mode leds equal");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("accepted word gave no result");

endmodule

`default_nettype wire

// File: rtl/tbbmc_button.sv
// per-button press tracking: saturating up counter, hold mark, click and hold detection
// depends on tbbmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbbmc_button #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          step,
  input  wire                          pressed,
  input  wire                          combo,
  input  wire [tbbmc_pkg::REG_W-1:0]   hold_time,
  input  wire [tbbmc_pkg::REG_W-1:0]   min_click,
  output tbbmc_pkg::btn_status_t       status
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > tbbmc_pkg::REG_W) ? COUNT_WIDTH : tbbmc_pkg::REG_W;

  logic                   last;
  logic                   done;
  logic [COUNT_WIDTH-1:0] ticks;

  logic                   last_next;
  logic                   done_next;
  logic [COUNT_WIDTH-1:0] ticks_next;
  logic [COUNT_WIDTH-1:0] ticks_inc;
  logic [CMP_W-1:0]       ticks_cmp;
  logic [CMP_W-1:0]       inc_cmp;
  logic [CMP_W-1:0]       hold_cmp;
  logic [CMP_W-1:0]       min_cmp;
  logic                   hold_ev;
  logic                   click_ev;

  always_comb begin
    if (last && !(&ticks)) begin
      ticks_inc = ticks + COUNT_WIDTH'(1);
    end else begin
      ticks_inc = ticks;
    end
  end

  assign inc_cmp  = CMP_W'(ticks_inc);
  assign ticks_cmp = CMP_W'(ticks_next);
  assign hold_cmp = CMP_W'(hold_time);
  assign min_cmp  = CMP_W'(min_click);

  always_comb begin
    hold_ev   = 1'b0;
    click_ev  = 1'b0;
    last_next = pressed;
    done_next = done;
    ticks_next = ticks_inc;
    if (combo) begin
      last_next = 1'b1;
      done_next = 1'b1;
    end else if (pressed) begin
      if (!last) begin
        ticks_next = '0;
        done_next  = 1'b0;
      end
      if (ticks_cmp >= hold_cmp && !done_next) begin
        hold_ev   = 1'b1;
        done_next = 1'b1;
      end
    end else begin
      click_ev = last && !done && (inc_cmp > min_cmp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last  <= 1'b0;
      done  <= 1'b0;
      ticks <= '0;
    end else if (step) begin
      last  <= last_next;
      done  <= done_next;
      ticks <= ticks_next;
    end
  end

  assign status.last  = last;
  assign status.hold  = hold_ev;
  assign status.click = click_ev;

endmodule

`default_nettype wire

// File: rtl/tbbmc_blink.sv
// mode register and blink phase generator with saturating elapsed counter
// depends on tbbmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tbbmc_blink #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          step,
  input  wire tbbmc_pkg::event_t       ev,
  input  wire [tbbmc_pkg::REG_W-1:0]   slow_period,
  input  wire [tbbmc_pkg::REG_W-1:0]   fast_period,
  output tbbmc_pkg::mode_t             mode_next,
  output logic                         red,
  output logic                         blue
);

  localparam int unsigned CMP_W =
    (COUNT_WIDTH > tbbmc_pkg::REG_W) ? COUNT_WIDTH : tbbmc_pkg::REG_W;

  tbbmc_pkg::mode_t       mode;
  logic                   phase;
  logic [COUNT_WIDTH-1:0] elapsed;

  logic                   phase_next;
  logic [COUNT_WIDTH-1:0] elapsed_next;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic [tbbmc_pkg::REG_W-1:0] period;
  logic                   blinking;
  logic                   slow;

  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + COUNT_WIDTH'(1);

  always_comb begin
    unique case (ev)
      tbbmc_pkg::EV_B1_CLICK: mode_next = tbbmc_pkg::MODE_SLOW_SYNC;
      tbbmc_pkg::EV_B2_CLICK: mode_next = tbbmc_pkg::MODE_FAST_SYNC;
      tbbmc_pkg::EV_B1_HOLD:  mode_next = tbbmc_pkg::MODE_SLOW_ALT;
      tbbmc_pkg::EV_B2_HOLD:  mode_next = tbbmc_pkg::MODE_FAST_ALT;
      tbbmc_pkg::EV_BOTH:     mode_next = tbbmc_pkg::MODE_OFF;
      default:                mode_next = mode;
    endcase
  end

  assign blinking = (mode_next != tbbmc_pkg::MODE_OFF);
  assign slow     = (mode_next == tbbmc_pkg::MODE_SLOW_SYNC) ||
                    (mode_next == tbbmc_pkg::MODE_SLOW_ALT);
  assign period   = slow ? slow_period : fast_period;

  always_comb begin
    elapsed_next = elapsed_inc;
    phase_next   = phase;
    if (blinking && (CMP_W'(elapsed_inc) >= CMP_W'(period))) begin
      elapsed_next = '0;
      phase_next   = !phase;
    end
  end

  always_comb begin
    red  = 1'b0;
    blue = 1'b0;
    if (blinking) begin
      red = phase_next;
      if ((mode_next == tbbmc_pkg::MODE_FAST_SYNC) ||
          (mode_next == tbbmc_pkg::MODE_SLOW_SYNC)) begin
        blue = phase_next;
      end else begin
        blue = !phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= tbbmc_pkg::MODE_OFF;
      phase   <= 1'b0;
      elapsed <= '0;
    end else if (step) begin
      mode    <= mode_next;
      phase   <= phase_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

`default_nettype wire
